// ----- rtl/core/afc_pkg.sv -----
// ---------------------------------------------------------------------------
// afc_pkg
// shared types and constants of the auto-ranging frequency counter
// ---------------------------------------------------------------------------
package afc_pkg;

   localparam int CLOCK_WIDTH       = 27;
   localparam int CODE_WIDTH        = 3;
   localparam int THRESH_WIDTH      = 16;
   localparam int COUNT_FIELD_WIDTH = 16;
   localparam int ACTION_WIDTH      = 2;
   localparam int INDEX_WIDTH       = 2;
   localparam int SHIFT_WIDTH       = 4;

   localparam logic [CLOCK_WIDTH-1:0]  CLOCK_RESET  = CLOCK_WIDTH'(16000000);
   localparam logic [CODE_WIDTH-1:0]   LOW_RESET    = CODE_WIDTH'(4);
   localparam logic [CODE_WIDTH-1:0]   HIGH_RESET   = CODE_WIDTH'(1);
   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(1000);

   localparam logic [ACTION_WIDTH-1:0] ACT_CAPTURE  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_OVERFLOW = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_START    = 2'd2;

   localparam logic [INDEX_WIDTH-1:0] REG_CLOCK_HZ  = 2'd0;
   localparam logic [INDEX_WIDTH-1:0] REG_LOW_CODE  = 2'd1;
   localparam logic [INDEX_WIDTH-1:0] REG_HIGH_CODE = 2'd2;
   localparam logic [INDEX_WIDTH-1:0] REG_THRESHOLD = 2'd3;

   localparam logic [CODE_WIDTH-1:0] CODE_DIV1    = 3'd1;
   localparam logic [CODE_WIDTH-1:0] CODE_DIV8    = 3'd2;
   localparam logic [CODE_WIDTH-1:0] CODE_DIV64   = 3'd3;
   localparam logic [CODE_WIDTH-1:0] CODE_DIV256  = 3'd4;
   localparam logic [CODE_WIDTH-1:0] CODE_DIV1024 = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

   // prescale factors are powers of two, so the second division is a shift
   function automatic logic [SHIFT_WIDTH-1:0] factor_shift(input logic [CODE_WIDTH-1:0] code);
      logic [SHIFT_WIDTH-1:0] sh;
      case (code)
         CODE_DIV1:    sh = 4'd0;
         CODE_DIV8:    sh = 4'd3;
         CODE_DIV64:   sh = 4'd6;
         CODE_DIV256:  sh = 4'd8;
         CODE_DIV1024: sh = 4'd10;
         default:      sh = 4'd0;
      endcase
      return sh;
   endfunction

endpackage

// ----- rtl/core/afc_divider.sv -----
// ---------------------------------------------------------------------------
// afc_divider
// radix-2 restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module afc_divider
   import afc_pkg::*;
#(
   parameter int DIVISOR_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  div_ctl_type              ctl_in,
   output div_ctl_type              ctl_out,
   input  logic [CLOCK_WIDTH-1:0]   dividend,
   input  logic [DIVISOR_WIDTH-1:0] divisor,
   output logic [CLOCK_WIDTH-1:0]   quotient
);

   localparam int STEP_W = $clog2(CLOCK_WIDTH);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [DIVISOR_WIDTH-1:0] div_ff, div_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [CLOCK_WIDTH-1:0]   quo_ff, quo_in;
   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     last_step;

   assign trial     = {rem_ff, quo_ff[CLOCK_WIDTH-1]};
   assign diff      = trial - {1'b0, div_ff};
   assign last_step = (step_ff == STEP_W'(CLOCK_WIDTH - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (ctl_in.start) begin
         busy_in = 1'b1;
         step_in = '0;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[CLOCK_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[CLOCK_WIDTH-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign ctl_out.start = busy_ff;
   assign ctl_out.done  = done_ff;
   assign quotient      = quo_ff;

endmodule

// ----- rtl/core/autorange_frequency_counter.sv -----
// ---------------------------------------------------------------------------
// autorange_frequency_counter
// auto-ranging reciprocal frequency counter with a single serial divider
// ---------------------------------------------------------------------------
// channel  direction  fields
// req      in         tuser: action[1:0]  tdata: capture_count[15:0]
// rsp      out        tdata: frequency[26:0] range_code[29:27]  tuser: divide_error
// csr      in         we, index[1:0], wdata[26:0]
//
// items that need no division give their result in the cycle after acceptance;
// a capture that divides gives its result after 27 radix-2 divider steps, the
// divider's done register, a scaling step and the output load, which waits for a free output register.
// reset is synchronous and restores registers, range and frequency.
// one item is in work at a time; a full output register stalls the next item.
// ---------------------------------------------------------------------------
module autorange_frequency_counter
   import afc_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // capture_count
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // frequency, range_code, zero pad
   output logic [0:0]  rsp_tuser,   // divide_error
   input  logic        csr_we,
   input  logic [INDEX_WIDTH-1:0] csr_index,
   input  logic [CLOCK_WIDTH-1:0] csr_wdata
);

   localparam int CW_EFF = (COUNT_WIDTH < COUNT_FIELD_WIDTH) ? COUNT_WIDTH : COUNT_FIELD_WIDTH;

   state_type state_ff, state_in;

   logic [CLOCK_WIDTH-1:0]  clock_hz_ff, clock_hz_in;
   logic [CODE_WIDTH-1:0]   low_code_ff, low_code_in;
   logic [CODE_WIDTH-1:0]   high_code_ff, high_code_in;
   logic [THRESH_WIDTH-1:0] thresh_ff, thresh_in;

   logic [CODE_WIDTH-1:0]   range_ff, range_in;
   logic [CLOCK_WIDTH-1:0]  freq_ff, freq_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CLOCK_WIDTH-1:0]  out_freq_ff;
   logic [CODE_WIDTH-1:0]   out_range_ff;
   logic                    out_err_ff;

   logic                    req_fire;
   logic                    out_free;
   logic                    load_out;
   logic                    err_now;
   logic [CW_EFF-1:0]       count_eff;
   logic [THRESH_WIDTH-1:0] count_ext;

   div_ctl_type             div_req, div_stat;
   logic [CLOCK_WIDTH-1:0]  quotient;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign count_eff  = req_tdata[CW_EFF-1:0];
   assign count_ext  = THRESH_WIDTH'(count_eff);

   always_comb begin
      clock_hz_in  = clock_hz_ff;
      low_code_in  = low_code_ff;
      high_code_in = high_code_ff;
      thresh_in    = thresh_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CLOCK_HZ:  clock_hz_in  = csr_wdata;
            REG_LOW_CODE:  low_code_in  = csr_wdata[CODE_WIDTH-1:0];
            REG_HIGH_CODE: high_code_in = csr_wdata[CODE_WIDTH-1:0];
            REG_THRESHOLD: thresh_in    = csr_wdata[THRESH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      range_in      = range_ff;
      freq_in       = freq_ff;
      load_out      = 1'b0;
      err_now       = 1'b0;
      div_req.start = 1'b0;
      div_req.done  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               load_out = 1'b1;
               case (req_tuser)
                  ACT_CAPTURE: begin
                     if (range_ff != high_code_ff && count_ext < thresh_ff) begin
                        range_in = high_code_ff;
                     end else if (count_eff == '0) begin
                        err_now = 1'b1;
                     end else begin
                        load_out      = 1'b0;
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
                  ACT_OVERFLOW: begin
                     if (range_ff != low_code_ff) begin
                        range_in = low_code_ff;
                     end else begin
                        freq_in = '0;
                     end
                  end
                  ACT_START: begin
                     range_in = low_code_ff;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               freq_in  = quotient >> factor_shift(range_ff);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);

   afc_divider #(
      .DIVISOR_WIDTH(CW_EFF)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (div_req),
      .ctl_out  (div_stat),
      .dividend (clock_hz_ff),
      .divisor  (count_eff),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_hz_ff  <= CLOCK_RESET;
         low_code_ff  <= LOW_RESET;
         high_code_ff <= HIGH_RESET;
         thresh_ff    <= THRESH_RESET;
         range_ff     <= LOW_RESET;
         freq_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         out_freq_ff  <= '0;
         out_range_ff <= LOW_RESET;
         out_err_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_hz_ff  <= clock_hz_in;
         low_code_ff  <= low_code_in;
         high_code_ff <= high_code_in;
         thresh_ff    <= thresh_in;
         range_ff     <= range_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_out) begin
            out_freq_ff  <= freq_in;
            out_range_ff <= range_in;
            out_err_ff   <= err_now;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_range_ff, out_freq_ff};
   assign rsp_tuser  = out_err_ff;

`ifndef SYNTHESIS
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_start_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> count_eff != '0)
      else $error("divider started with a zero count");

   a_out_hold_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("output item changed while dividing");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// stream-level testbench of the auto-ranging frequency counter: a queue-fed
// driver offers capture, overflow, start and unused events, a monitor checks
// every result against an in-bench prediction of range, frequency and divide error, and
// the register set is changed between phases while the block is idle
// ---------------------------------------------------------------------------
module tb;
   import afc_pkg::*;

   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]      action;
      logic [COUNT_FIELD_WIDTH-1:0] count;
   } event_type;

   typedef struct packed {
      logic [CLOCK_WIDTH-1:0] frequency;
      logic [CODE_WIDTH-1:0]  range_code;
      logic                   divide_error;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [15:0]                  req_tdata  = '0;   // capture_count
   logic [1:0]                   req_tuser  = '0;   // action
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [31:0]                  rsp_tdata;         // frequency, range_code, zero pad
   logic [0:0]                   rsp_tuser;         // divide_error
   logic                         csr_we     = 1'b0;
   logic [INDEX_WIDTH-1:0]       csr_index  = '0;
   logic [CLOCK_WIDTH-1:0]       csr_wdata  = '0;

   autorange_frequency_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copies and measurement state
   logic [CLOCK_WIDTH-1:0]  cfg_clock_hz = CLOCK_RESET;
   logic [CODE_WIDTH-1:0]   cfg_low      = LOW_RESET;
   logic [CODE_WIDTH-1:0]   cfg_high     = HIGH_RESET;
   logic [THRESH_WIDTH-1:0] cfg_thresh   = THRESH_RESET;
   logic [CODE_WIDTH-1:0]   range_now    = LOW_RESET;
   logic [CLOCK_WIDTH-1:0]  freq_now     = '0;

   event_type   event_queue[$];
   reading_type pending_readings[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  mismatches    = 0;
   int  hold_left     = 0;
   logic hold_trigger = 1'b0;

   event_type   next_event;
   reading_type seen, wanted;

   function automatic logic [10:0] prescale_divisor(input logic [CODE_WIDTH-1:0] code);
      case (code)
         CODE_DIV8:    return 11'd8;
         CODE_DIV64:   return 11'd64;
         CODE_DIV256:  return 11'd256;
         CODE_DIV1024: return 11'd1024;
         default:      return 11'd1;
      endcase
   endfunction

   task automatic measure_event(input logic [ACTION_WIDTH-1:0] action,
                                input logic [COUNT_FIELD_WIDTH-1:0] count);
      reading_type r;
      logic [CLOCK_WIDTH-1:0] q;
      r.divide_error = 1'b0;
      case (action)
         ACT_CAPTURE: begin
            if (range_now != cfg_high && count < cfg_thresh) begin
               range_now = cfg_high;
            end else if (count == '0) begin
               r.divide_error = 1'b1;
            end else begin
               q = cfg_clock_hz / CLOCK_WIDTH'(count);
               freq_now = q / CLOCK_WIDTH'(prescale_divisor(range_now));
            end
         end
         ACT_OVERFLOW: begin
            if (range_now != cfg_low) range_now = cfg_low;
            else freq_now = '0;
         end
         ACT_START: range_now = cfg_low;
         default: ;
      endcase
      r.frequency  = freq_now;
      r.range_code = range_now;
      pending_readings.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) measure_event(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_event = event_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_event.action;
               req_tdata  <= next_event.count;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_trigger) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.frequency    = rsp_tdata[26:0];
            seen.range_code   = rsp_tdata[29:27];
            seen.divide_error = rsp_tuser[0];
            if (pending_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected item: freq %0d range %0d err %0d",
                           seen.frequency, seen.range_code, seen.divide_error);
            end else begin
               wanted = pending_readings.pop_front();
               if (seen !== wanted) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: exp f=%0d r=%0d e=%0d, got f=%0d r=%0d e=%0d",
                              wanted.frequency, wanted.range_code, wanted.divide_error,
                              seen.frequency, seen.range_code, seen.divide_error);
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      while (event_queue.size() != 0 || req_tvalid || pending_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [CLOCK_WIDTH-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_CLOCK_HZ:  cfg_clock_hz = val;
         REG_LOW_CODE:  cfg_low      = val[CODE_WIDTH-1:0];
         REG_HIGH_CODE: cfg_high     = val[CODE_WIDTH-1:0];
         REG_THRESHOLD: cfg_thresh   = val[THRESH_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic push_event(input logic [ACTION_WIDTH-1:0] action,
                             input logic [COUNT_FIELD_WIDTH-1:0] count);
      event_type e;
      e.action = action;
      e.count  = count;
      event_queue.push_back(e);
   endtask

   function automatic logic [COUNT_FIELD_WIDTH-1:0] pick_count();
      int t;
      case ($urandom_range(9))
         0:       return '0;
         1:       return 16'hFFFF;
         2, 3:    return COUNT_FIELD_WIDTH'($urandom_range(15));
         4, 5: begin
            t = int'(cfg_thresh) + int'($urandom_range(2)) - 1;
            if (t < 0) t = 0;
            if (t > 65535) t = 65535;
            return COUNT_FIELD_WIDTH'(t);
         end
         default: return COUNT_FIELD_WIDTH'($urandom);
      endcase
   endfunction

   task automatic push_random(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(19);
         if (r < 12)      push_event(ACT_CAPTURE, pick_count());
         else if (r < 15) push_event(ACT_OVERFLOW, COUNT_FIELD_WIDTH'($urandom));
         else if (r < 18) push_event(ACT_START, COUNT_FIELD_WIDTH'($urandom));
         else             push_event(ACT_UNUSED, COUNT_FIELD_WIDTH'($urandom));
      end
   endtask

   task automatic run_phase(input logic [CLOCK_WIDTH-1:0] hz, input logic [CODE_WIDTH-1:0] lo,
                            input logic [CODE_WIDTH-1:0] hi, input logic [THRESH_WIDTH-1:0] thr,
                            input int n, input int sp, input int rp, input bit hold);
      wait_idle();
      // junk above the code and threshold widths
      write_reg(REG_CLOCK_HZ, hz);
      write_reg(REG_LOW_CODE, CLOCK_WIDTH'({CLOCK_WIDTH'($urandom) >> CODE_WIDTH, lo}));
      write_reg(REG_HIGH_CODE, CLOCK_WIDTH'({CLOCK_WIDTH'($urandom) >> CODE_WIDTH, hi}));
      write_reg(REG_THRESHOLD, CLOCK_WIDTH'({CLOCK_WIDTH'($urandom) >> THRESH_WIDTH, thr}));
      @(negedge clock);
      send_idle_pct = sp;
      recv_idle_pct = rp;
      push_random(n / 2);
      wait_idle();
      if (hold) begin
         @(posedge clock);
         hold_trigger <= 1'b1;
         @(posedge clock);
         hold_trigger <= 1'b0;
         @(negedge clock);
      end
      push_random(n - n / 2);
      wait_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 23;
      recv_idle_pct = 62;

      // reset settings: low range 256, high range 1, threshold 1000
      push_event(ACT_CAPTURE, 16'hFFFF);
      push_event(ACT_CAPTURE, 16'd5000);
      push_event(ACT_CAPTURE, 16'd500);   // switch to high range
      push_event(ACT_CAPTURE, 16'd500);
      push_event(ACT_CAPTURE, 16'd0);     // refused zero count
      push_event(ACT_CAPTURE, 16'd1);
      push_event(ACT_OVERFLOW, 16'hFFFF); // back to low range
      push_event(ACT_OVERFLOW, 16'd0);    // clears frequency
      push_event(ACT_UNUSED, 16'hFFFF);
      push_event(ACT_CAPTURE, 16'd1000);  // at threshold, no switch
      push_event(ACT_CAPTURE, 16'd999);
      push_event(ACT_START, 16'h5A5A);
      push_event(ACT_CAPTURE, 16'd0);     // zero below threshold switches
      push_event(ACT_CAPTURE, 16'd0);
      push_event(ACT_START, 16'd0);
      push_event(ACT_UNUSED, 16'd0);
      push_event(ACT_CAPTURE, 16'd1);
      push_event(ACT_CAPTURE, 16'h8000);
      wait_idle();

      run_phase(27'd100000000, CODE_DIV1024, CODE_DIV1, 16'hFFFF, 110, 23, 62, 1'b0);
      run_phase(27'd1, CODE_DIV1, CODE_DIV1024, 16'd0, 110, 23, 62, 1'b0);
      run_phase(27'd0, CODE_DIV64, CODE_DIV8, 16'd200, 110, 62, 23, 1'b0);
      run_phase(27'h7FFFFFF, CODE_DIV256, CODE_DIV1, 16'd40, 110, 62, 23, 1'b0);
      // invalid prescale codes
      run_phase(CLOCK_WIDTH'($urandom), 3'd0, 3'd7, 16'd300, 110, 62, 23, 1'b0);
      run_phase(CLOCK_WIDTH'($urandom), 3'd6, 3'd6, 16'd300, 110, 0, 0, 1'b1);
      run_phase(27'd8000000, CODE_DIV8, CODE_DIV256, 16'd5000, 110, 0, 0, 1'b0);
      run_phase(CLOCK_WIDTH'($urandom), CODE_WIDTH'($urandom), CODE_WIDTH'($urandom),
                THRESH_WIDTH'($urandom), 110, 0, 0, 1'b1);

      repeat (50) @(posedge clock);
      if (pending_readings.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
